FILE: src/tesf_pkg.sv
// Package for the terminal escape sequence filter: payload types, states and byte codes.
package tesf_pkg;

  // Byte codes that the parser recognizes.
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_DIGIT9    = 8'h39;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_GREATER   = 8'h3E;
  localparam logic [7:0] CH_LESS      = 8'h3C;

  // Input request: one raw byte and the end-of-string flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  // Result request: the byte, its keep flag and the last flag.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic       out_last;
  } out_t;

  // Parser states, one-hot.
  typedef enum logic [6:0] {
    ST_GROUND  = 7'b0000001,
    ST_ESC     = 7'b0000010,
    ST_CSI     = 7'b0000100,
    ST_OSC     = 7'b0001000,
    ST_OSC_ESC = 7'b0010000,
    ST_CHARSET = 7'b0100000,
    ST_DIGITS  = 7'b1000000
  } state_t;

endpackage

FILE: src/terminal_escape_sequence_filter_unit.sv
// Top level of the terminal escape sequence filter.
//
// Usage: bytes of a terminal stream enter on the in_ channel (valid/ready),
// each with a flag marking the last byte of its string. For every input
// request exactly one result request leaves on the out_ channel: the same
// byte, a keep flag (0 for bytes of ANSI escape/control sequences and for
// control bytes other than tab, newline and carriage return) and a copy of
// the last flag. After a byte flagged as last, the parser returns to ground.
// An accepted input waits in the input register and moves on to the result
// register, where its result is offered, once that register frees.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the parser state update between the input register and the result register.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// in ground. When the receiver stalls, the result holds and at most one more
// input is still taken into the input register before in_ready falls.
module terminal_escape_sequence_filter_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tesf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tesf_pkg::out_t out_data
);

  tesf_pkg::in_t    in_r;
  logic             in_valid_r;
  tesf_pkg::out_t   out_r;
  logic             out_valid_r;
  tesf_pkg::state_t state_r;
  tesf_pkg::state_t state_nxt;
  logic             keep_nxt;
  logic             advance;
  logic             xfer;
  logic [7:0]       c;
  logic             is_digit;
  logic             is_param;
  logic             is_ctrl_drop;

  // Handshake: the result register frees when empty or taken, the input
  // register when empty or moving on.
  assign advance   = !out_valid_r || out_ready;
  assign xfer      = in_valid_r && advance;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Byte classes.
  assign c        = in_r.in_byte;
  assign is_digit = (c >= tesf_pkg::CH_DIGIT0) && (c <= tesf_pkg::CH_DIGIT9);
  assign is_param = is_digit || (c == tesf_pkg::CH_SEMI) || (c == tesf_pkg::CH_QUESTION) ||
                    (c == tesf_pkg::CH_BANG) || (c == tesf_pkg::CH_EQUAL) ||
                    (c == tesf_pkg::CH_GREATER) || (c == tesf_pkg::CH_LESS);
  assign is_ctrl_drop = (c < tesf_pkg::CH_SPACE) && (c != tesf_pkg::CH_TAB) &&
                        (c != tesf_pkg::CH_LF) && (c != tesf_pkg::CH_CR);

  // Parser next state and keep decision.
  always_comb begin
    state_nxt = tesf_pkg::ST_GROUND;
    keep_nxt  = 1'b0;
    case (state_r)
      tesf_pkg::ST_ESC: begin
        if (c == tesf_pkg::CH_LBRACKET) begin
          state_nxt = tesf_pkg::ST_CSI;
        end else if (c == tesf_pkg::CH_RBRACKET) begin
          state_nxt = tesf_pkg::ST_OSC;
        end else if ((c == tesf_pkg::CH_LPAREN) || (c == tesf_pkg::CH_RPAREN)) begin
          state_nxt = tesf_pkg::ST_CHARSET;
        end else if (is_digit) begin
          state_nxt = tesf_pkg::ST_DIGITS;
        end
      end
      tesf_pkg::ST_CSI: begin
        if (is_param) begin
          state_nxt = tesf_pkg::ST_CSI;
        end
      end
      tesf_pkg::ST_OSC, tesf_pkg::ST_OSC_ESC: begin
        if ((state_r == tesf_pkg::ST_OSC_ESC) && (c == tesf_pkg::CH_BACKSLASH)) begin
          state_nxt = tesf_pkg::ST_GROUND;
        end else if (c == tesf_pkg::CH_BEL) begin
          state_nxt = tesf_pkg::ST_GROUND;
        end else if (c == tesf_pkg::CH_ESC) begin
          state_nxt = tesf_pkg::ST_OSC_ESC;
        end else begin
          state_nxt = tesf_pkg::ST_OSC;
        end
      end
      tesf_pkg::ST_CHARSET: begin
        state_nxt = tesf_pkg::ST_GROUND;
      end
      tesf_pkg::ST_DIGITS: begin
        if (is_digit) begin
          state_nxt = tesf_pkg::ST_DIGITS;
        end else if (c == tesf_pkg::CH_ESC) begin
          state_nxt = tesf_pkg::ST_ESC;
        end else begin
          keep_nxt = !is_ctrl_drop;
        end
      end
      default: begin
        // Ground handling.
        if (c == tesf_pkg::CH_ESC) begin
          state_nxt = tesf_pkg::ST_ESC;
        end else begin
          keep_nxt = !is_ctrl_drop;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= tesf_pkg::ST_GROUND;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (xfer) begin
        state_r <= in_r.end_of_string ? tesf_pkg::ST_GROUND : state_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (xfer) begin
      out_r.out_byte <= in_r.in_byte;
      out_r.keep     <= keep_nxt;
      out_r.out_last <= in_r.end_of_string;
    end
  end

`ifndef SYNTHESIS
  // The last byte of a string always sends the parser back to ground.
  a_last_ground: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_r.end_of_string) |=> (state_r == tesf_pkg::ST_GROUND))
    else $error("parser not in ground after last byte");

  // An escape byte is never kept.
  a_esc_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.keep) |-> (out_r.out_byte != tesf_pkg::CH_ESC))
    else $error("escape byte kept");

  // Only tab, newline and carriage return survive among control bytes.
  a_ctrl_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.keep && (out_r.out_byte < tesf_pkg::CH_SPACE)) |->
    ((out_r.out_byte == tesf_pkg::CH_TAB) || (out_r.out_byte == tesf_pkg::CH_LF) ||
     (out_r.out_byte == tesf_pkg::CH_CR)))
    else $error("control byte kept");

  // A stalled result does not move the parser or the result register.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(state_r) && $stable(out_r)))
    else $error("state moved during stall");
`endif

endmodule
